// ===== rtl/rsp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsp_pkg
// Types and constants shared by the stream parser controller and datapath.
// ----------------------------------------------------------------------------
package rsp_pkg;

	typedef enum logic [2:0] {
		PH_PREFIX    = 3'd0,
		PH_LINE      = 3'd1,
		PH_NUM_START = 3'd2,
		PH_NUM       = 3'd3,
		PH_BULK_DATA = 3'd4,
		PH_BULK_CR   = 3'd5,
		PH_BULK_LF   = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		ST_RUN  = 2'd0,
		ST_OUT2 = 2'd1,
		ST_FAIL = 2'd2
	} ctl_state_t;

	localparam logic [2:0] K_PAYLOAD = 3'd0;
	localparam logic [2:0] K_INT     = 3'd1;
	localparam logic [2:0] K_BULK    = 3'd2;
	localparam logic [2:0] K_ARRAY   = 3'd3;
	localparam logic [2:0] K_END     = 3'd4;
	localparam logic [2:0] K_ERROR   = 3'd5;

	localparam logic [2:0] VT_SIMPLE = 3'd0;
	localparam logic [2:0] VT_ERRSTR = 3'd1;
	localparam logic [2:0] VT_INT    = 3'd2;
	localparam logic [2:0] VT_BULK   = 3'd3;
	localparam logic [2:0] VT_ARRAY  = 3'd4;

	localparam logic [3:0] E_NONE   = 4'd0;
	localparam logic [3:0] E_NO_CR  = 4'd1;
	localparam logic [3:0] E_DIGITS = 4'd2;
	localparam logic [3:0] E_RANGE  = 4'd3;
	localparam logic [3:0] E_EMPTY  = 4'd4;
	localparam logic [3:0] E_PREFIX = 4'd5;
	localparam logic [3:0] E_BULK   = 4'd6;
	localparam logic [3:0] E_EARLY  = 4'd7;
	localparam logic [3:0] E_DEEP   = 4'd8;

	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR  = 8'h2a;

	// Command from the controller to the datapath.
	typedef struct packed {
		logic       step;      // consume the input byte
		logic       eos;       // input beat is end of stream
		logic       pop_out2;  // second result was taken
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic       n1;        // step gives a first result
		logic       n2;        // step gives a second result
		logic       err;       // step raises an error
	} dp_sts_t;

	// Result item: kind, value_type, payload_byte, number, depth, top, error.
	typedef struct packed {
		logic [2:0]  kind;
		logic [2:0]  vt;
		logic [7:0]  pb;
		logic [63:0] num;
		logic [3:0]  depth;
		logic        top;
		logic [3:0]  ecode;
	} res_t;

endpackage
`default_nettype wire

// ===== rtl/rsp_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsp_ctrl
// Handshake controller: accepts beats, sequences one or two results into the
// output register and parks in the failed state after an error.
// ----------------------------------------------------------------------------
module rsp_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             in_eos,
	output logic                  in_ready,
	input  wire rsp_pkg::dp_sts_t sts,
	output rsp_pkg::dp_cmd_t      cmd,
	output logic                  load1,
	output logic                  load2,
	output logic                  ovalid,
	input  wire logic             oready
);
	import rsp_pkg::*;

	ctl_state_t state_q, state_d;
	logic       ovalid_q, ovalid_d;
	logic       free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_RUN;
			ovalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			ovalid_q <= ovalid_d;
		end
	end

	// Output register can take a new result when empty or being drained.
	assign free   = !ovalid_q || oready;
	assign ovalid = ovalid_q;

	always_comb begin
		state_d  = state_q;
		ovalid_d = ovalid_q && !oready;
		in_ready = 1'b0;
		cmd      = '0;
		load1    = 1'b0;
		load2    = 1'b0;
		case (state_q)
			ST_RUN: begin
				in_ready = free;
				cmd.eos  = in_eos;
				if (in_valid && free) begin
					cmd.step = 1'b1;
					if (sts.n1) begin
						load1    = 1'b1;
						ovalid_d = 1'b1;
					end
					if (sts.n2) state_d = ST_OUT2;
					else if (sts.err) state_d = ST_FAIL;
				end
			end
			ST_OUT2: begin
				if (free) begin
					load2        = 1'b1;
					ovalid_d     = 1'b1;
					cmd.pop_out2 = 1'b1;
					state_d      = ST_RUN;
				end
			end
			ST_FAIL: begin
				in_ready = 1'b1;
			end
			default: state_d = ST_RUN;
		endcase
	end
endmodule
`default_nettype wire

// ===== rtl/rsp_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsp_datapath
// Parser state, number accumulator, bulk counter, count stack and the
// output result register.
// ----------------------------------------------------------------------------
module rsp_datapath #(
	parameter int MAX_DEPTH   = 8,
	parameter int COUNT_WIDTH = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [7:0]       data_byte,
	input  wire logic [31:0]      max_bulk,
	input  wire logic [31:0]      max_array,
	input  wire rsp_pkg::dp_cmd_t cmd,
	input  wire logic             load1,
	input  wire logic             load2,
	output rsp_pkg::dp_sts_t      sts,
	output rsp_pkg::res_t         res
);
	import rsp_pkg::*;

	localparam int SPW = $clog2(MAX_DEPTH + 1);
	localparam int IW  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

	phase_t                 phase_q, phase_d;
	logic [2:0]             ctype_q, ctype_d;
	logic                   held_q, held_d;
	logic [63:0]            acc_q, acc_d;
	logic                   neg_q, neg_d;
	logic                   seen_q, seen_d;
	logic [31:0]            brem_q, brem_d;
	logic [COUNT_WIDTH-1:0] stk_q [MAX_DEPTH];
	logic [SPW-1:0]         sp_q, sp_d;
	res_t                   r1, r2, res_q, r2_q;

	// Leaf completion: decrement the top counts until one stays nonzero.
	logic [MAX_DEPTH-1:0]   one;
	logic                   leaf, push, top;
	logic [SPW-1:0]         sp_leaf;
	logic [COUNT_WIDTH-1:0] push_v;

	always_comb begin
		for (int i = 0; i < MAX_DEPTH; i++) one[i] = (stk_q[i] == COUNT_WIDTH'(1));
	end

	always_comb begin
		logic go;
		go      = 1'b1;
		sp_leaf = sp_q;
		for (int i = MAX_DEPTH - 1; i >= 0; i--) begin
			if (go && (sp_q > SPW'(i))) begin
				if (one[i]) sp_leaf = SPW'(i);
				else go = 1'b0;
			end
		end
		top = (sp_leaf == '0);
	end

	// Digit check: acc*10+d must stay within the limit.
	logic [7:0]  dig;
	logic        isdig;
	logic [67:0] prod;
	logic [63:0] limit;
	logic        ovf;
	assign dig   = data_byte - 8'h30;
	assign isdig = (data_byte >= 8'h30) && (data_byte <= 8'h39);
	assign prod  = {4'd0, acc_q} * 68'd10 + {60'd0, dig[3:0]};
	assign limit = neg_q ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
	assign ovf   = (prod > {4'd0, limit});

	function automatic res_t mk(logic [2:0] k, logic [2:0] v, logic [7:0] b,
		logic [63:0] n, logic [SPW-1:0] d, logic t, logic [3:0] e);
		res_t r;
		r.kind = k; r.vt = v; r.pb = b; r.num = n;
		r.depth = 4'(d); r.top = t; r.ecode = e;
		return r;
	endfunction

	always_comb begin
		logic [7:0] b;
		logic [3:0] ec;
		logic       e;
		b       = data_byte;
		ec      = E_NONE;
		e       = 1'b0;
		phase_d = phase_q;
		ctype_d = ctype_q;
		held_d  = held_q;
		acc_d   = acc_q;
		neg_d   = neg_q;
		seen_d  = seen_q;
		brem_d  = brem_q;
		sp_d    = sp_q;
		leaf    = 1'b0;
		push    = 1'b0;
		push_v  = acc_q[COUNT_WIDTH-1:0];
		sts     = '0;
		r1      = '0;
		r2      = '0;
		if (cmd.eos) begin
			if (phase_q != PH_PREFIX || sp_q != '0) begin
				e = 1'b1; ec = E_EARLY;
			end
		end else begin
			case (phase_q)
				PH_PREFIX: begin
					held_d = 1'b0; acc_d = '0; neg_d = 1'b0; seen_d = 1'b0;
					case (b)
						CH_PLUS:   begin ctype_d = VT_SIMPLE; phase_d = PH_LINE; end
						CH_MINUS:  begin ctype_d = VT_ERRSTR; phase_d = PH_LINE; end
						CH_COLON:  begin ctype_d = VT_INT; phase_d = PH_NUM_START; end
						CH_DOLLAR: begin ctype_d = VT_BULK; phase_d = PH_NUM_START; end
						CH_STAR:   begin ctype_d = VT_ARRAY; phase_d = PH_NUM_START; end
						default:   begin ctype_d = VT_SIMPLE; e = 1'b1; ec = E_PREFIX; end
					endcase
				end
				PH_LINE: begin
					if (held_q) begin
						if (b == CH_LF) begin
							held_d = 1'b0; leaf = 1'b1;
							sts.n1 = 1'b1;
							r1 = mk(K_END, ctype_q, 8'd0, 64'd0, sp_q, top, E_NONE);
						end else begin
							sts.n1 = 1'b1;
							r1 = mk(K_PAYLOAD, ctype_q, CH_CR, 64'd0, sp_q, 1'b0, E_NONE);
							if (b != CH_CR) begin
								held_d = 1'b0; sts.n2 = 1'b1;
								r2 = mk(K_PAYLOAD, ctype_q, b, 64'd0, sp_q, 1'b0, E_NONE);
							end
						end
					end else if (b == CH_CR) held_d = 1'b1;
					else if (b == CH_LF) begin e = 1'b1; ec = E_NO_CR; end
					else begin
						sts.n1 = 1'b1;
						r1 = mk(K_PAYLOAD, ctype_q, b, 64'd0, sp_q, 1'b0, E_NONE);
					end
				end
				PH_NUM_START, PH_NUM: begin
					if (held_q) begin
						held_d = 1'b0;
						if (b != CH_LF) begin e = 1'b1; ec = E_DIGITS; end
						else if (!seen_q) begin e = 1'b1; ec = E_DIGITS; end
						else if (ctype_q == VT_INT) begin
							leaf = 1'b1; sts.n1 = 1'b1;
							r1 = mk(K_INT, VT_INT, 8'd0, neg_q ? (64'd0 - acc_q) : acc_q,
								sp_q, top, E_NONE);
						end else if (ctype_q == VT_BULK) begin
							if (acc_q > {32'd0, max_bulk}) begin e = 1'b1; ec = E_RANGE; end
							else begin
								sts.n1 = 1'b1;
								r1 = mk(K_BULK, VT_BULK, 8'd0, acc_q, sp_q, 1'b0, E_NONE);
								brem_d = acc_q[31:0];
								phase_d = (acc_q != 64'd0) ? PH_BULK_DATA : PH_BULK_CR;
							end
						end else begin
							if (acc_q > {32'd0, max_array} ||
								(COUNT_WIDTH < 64 && (acc_q >> COUNT_WIDTH) != 64'd0)) begin
								e = 1'b1; ec = E_RANGE;
							end else if (acc_q == 64'd0) begin e = 1'b1; ec = E_EMPTY; end
							else if (sp_q >= SPW'(MAX_DEPTH)) begin e = 1'b1; ec = E_DEEP; end
							else begin
								sts.n1 = 1'b1; push = 1'b1;
								r1 = mk(K_ARRAY, VT_ARRAY, 8'd0, acc_q, sp_q, 1'b0, E_NONE);
								sp_d = sp_q + 1'b1;
								phase_d = PH_PREFIX;
							end
						end
					end else if (b == CH_CR) held_d = 1'b1;
					else if (b == CH_LF) begin e = 1'b1; ec = E_NO_CR; end
					else if ((b == CH_PLUS || b == CH_MINUS) && phase_q == PH_NUM_START
						&& ctype_q == VT_INT) begin
						neg_d = (b == CH_MINUS); phase_d = PH_NUM;
					end else if (isdig) begin
						if (ovf) begin e = 1'b1; ec = E_RANGE; end
						else begin acc_d = prod[63:0]; seen_d = 1'b1; phase_d = PH_NUM; end
					end else begin e = 1'b1; ec = E_DIGITS; end
				end
				PH_BULK_DATA: begin
					sts.n1 = 1'b1;
					r1 = mk(K_PAYLOAD, VT_BULK, b, 64'd0, sp_q, 1'b0, E_NONE);
					brem_d = brem_q - 32'd1;
					if (brem_q == 32'd1) phase_d = PH_BULK_CR;
				end
				PH_BULK_CR: begin
					if (b == CH_CR) phase_d = PH_BULK_LF;
					else begin e = 1'b1; ec = E_BULK; end
				end
				PH_BULK_LF: begin
					if (b == CH_LF) begin
						leaf = 1'b1; sts.n1 = 1'b1;
						r1 = mk(K_END, ctype_q, 8'd0, 64'd0, sp_q, top, E_NONE);
					end else begin e = 1'b1; ec = E_BULK; end
				end
				default: phase_d = PH_PREFIX;
			endcase
		end
		if (e) begin
			sts.err = 1'b1; sts.n1 = 1'b1;
			r1 = mk(K_ERROR, ctype_d, 8'd0, 64'd0, sp_q, 1'b0, ec);
		end
		if (leaf) begin
			sp_d = sp_leaf; phase_d = PH_PREFIX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PREFIX;
			ctype_q <= VT_SIMPLE;
			held_q  <= 1'b0;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			seen_q  <= 1'b0;
			brem_q  <= '0;
			sp_q    <= '0;
		end else if (cmd.step) begin
			phase_q <= phase_d;
			ctype_q <= ctype_d;
			held_q  <= held_d;
			acc_q   <= acc_d;
			neg_q   <= neg_d;
			seen_q  <= seen_d;
			brem_q  <= brem_d;
			sp_q    <= sp_d;
		end
	end

	// Count stack: a leaf decrements the entry where the cascade of closing
	// arrays stops; the closed entries above it are dead until pushed again.
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			if (leaf && sp_leaf != '0)
				stk_q[IW'(sp_leaf - 1'b1)] <= stk_q[IW'(sp_leaf - 1'b1)] - 1'b1;
			if (push) stk_q[IW'(sp_q)] <= push_v;
		end
	end

	always_ff @(posedge clk) begin
		if (load1) begin
			res_q <= r1;
			r2_q  <= r2;
		end else if (load2) res_q <= r2_q;
	end

	assign res = res_q;
endmodule
`default_nettype wire

// ===== rtl/resp_stream_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// resp_stream_parser
// Byte stream parser for the line-oriented serialization protocol.
// ----------------------------------------------------------------------------
// The slave side takes one beat per byte: tdata holds the stream byte and
// tuser set marks end of stream. The master side gives one beat per result:
// kind, value type, payload byte, number, depth, top flag and error code in
// tdata, and tlast on the last result caused by an input beat.
// The first result of an accepted beat is loaded into the output register and
// appears there on the next cycle. A beat causing two results (a held CR and
// the following byte) holds off the next beat until its second result is
// loaded; else throughput is one byte per cycle unless the receiver stalls.
// Array completions resolve in the same cycle by a check for counts of one
// across the count stack.
// When the receiver stalls, the output register holds and the slave side
// stops accepting. Reset clears parser state bar the count stack and output
// result; both size limits return to their defaults. After an error no more
// results are given until reset; input beats are still accepted and dropped.
// ----------------------------------------------------------------------------
module resp_stream_parser #(
	parameter int MAX_DEPTH   = 8,
	parameter int COUNT_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // data_byte
	input  wire logic        s_tuser,  // end of stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// kind[2:0], value_type[5:3], payload_byte[13:6], number[77:14],
	// nesting_depth[81:78], top_complete[82], error_code[86:83], zero fill
	output logic [87:0]      m_tdata,
	output logic             m_tlast
);
	import rsp_pkg::*;

	localparam logic [0:0] R_BULK  = 1'b0;
	localparam logic [0:0] R_ARRAY = 1'b1;

	logic [31:0] max_bulk_q, max_array_q;
	dp_cmd_t     cmd;
	dp_sts_t     sts;
	logic        load1, load2, last_q;
	res_t        res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_bulk_q  <= 32'd536870912;
			max_array_q <= 32'd1048576;
		end else if (cfg_we) begin
			case (cfg_index)
				R_BULK:  max_bulk_q  <= cfg_data;
				R_ARRAY: max_array_q <= cfg_data;
				default: ;
			endcase
		end
	end

	rsp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_eos(s_tuser),
		.in_ready(s_tready), .sts(sts), .cmd(cmd), .load1(load1), .load2(load2),
		.ovalid(m_tvalid), .oready(m_tready)
	);

	rsp_datapath #(.MAX_DEPTH(MAX_DEPTH), .COUNT_WIDTH(COUNT_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .data_byte(s_tdata), .max_bulk(max_bulk_q),
		.max_array(max_array_q), .cmd(cmd), .load1(load1), .load2(load2),
		.sts(sts), .res(res)
	);

	always_ff @(posedge clk) begin
		if (load1) last_q <= !sts.n2;
		else if (load2) last_q <= 1'b1;
	end

	assign m_tdata = {1'b0, res.ecode, res.top, res.depth, res.num, res.pb,
		res.vt, res.kind};
	assign m_tlast = last_q;
endmodule
`default_nettype wire
